/* design/swps_pkg.sv */
// Shared types, codes and sizes for the sleep/wakeup priority scheduler.
package swps_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int CHANNEL_BITS  = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_W        = 6;
    localparam int CMP_W         = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // Operation codes carried in func.
    localparam logic [2:0] FUNC_WRITE  = 3'd0;
    localparam logic [2:0] FUNC_SLEEP  = 3'd1;
    localparam logic [2:0] FUNC_WAKEUP = 3'd2;
    localparam logic [2:0] FUNC_PICK   = 3'd3;
    localparam logic [2:0] FUNC_SWAPW  = 3'd4;

    // Entry status codes.
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_SLEEP = 2'd3;

    // Priority reported when nothing was chosen; also the pick ceiling.
    localparam logic signed [7:0] PRI_NONE = 8'sd127;

    // Woken count saturation value.
    localparam logic [6:0] WOKEN_MAX = 7'd127;

    // Input transaction.
    typedef struct packed {
        logic [2:0]        func;
        logic [5:0]        slot;
        logic [1:0]        status_in;
        logic              resident_in;
        logic signed [7:0] priority_req;
        logic [15:0]       channel;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic              found;
        logic [5:0]        chosen_slot;
        logic signed [7:0] chosen_priority;
        logic [6:0]        woken_count;
        logic              wake_swapper;
    } t_out_item;

    // One task table entry, held by one cell of the ring.
    typedef struct packed {
        logic [1:0]              status;
        logic                    resident;
        logic signed [7:0]       prio;
        logic [CHANNEL_BITS-1:0] channel;
    } t_entry;

    // Running pick and swapper state seen by the head unit.
    typedef struct packed {
        logic              found;
        logic              best_high;
        logic signed [7:0] best_pri;
        logic              swap_wait;
    } t_head_acc;

    // Events reported by the head unit for the entry under it.
    typedef struct packed {
        logic take;
        logic take_high;
        logic woke;
        logic release_swapper;
    } t_head_ev;

endpackage

/* design/swps_cell.sv */
// One ring cell: holds a single task entry and takes its neighbor's entry on each shift.
module swps_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  swps_pkg::t_entry i_next,
    output swps_pkg::t_entry o_entry
);
    import swps_pkg::*;

    t_entry r_entry;

    // Entry register; reset leaves the entry free, non-resident, priority and channel zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* design/swps_head.sv */
// Head unit: applies the current operation to the entry leaving the head of the ring.
module swps_head (
    input  swps_pkg::t_in_item          i_op,
    input  logic [swps_pkg::IDX_W-1:0]  i_idx,
    input  logic [swps_pkg::IDX_W-1:0]  i_last_pick,
    input  swps_pkg::t_head_acc         i_acc,
    input  swps_pkg::t_entry            i_entry,
    output swps_pkg::t_entry            o_entry,
    output swps_pkg::t_head_ev          o_ev
);
    import swps_pkg::*;

    logic [CHANNEL_BITS-1:0] w_chan;
    logic                    w_hit;
    logic                    w_chan_match;
    logic                    w_high;
    logic                    w_cand;
    logic                    w_better;

    // The channel is fitted to the stored width; slot compares at a common width.
    assign w_chan       = CHANNEL_BITS'(i_op.channel);
    assign w_hit        = (CMP_W'(i_idx) == CMP_W'(i_op.slot));
    assign w_chan_match = (w_chan != '0) && (i_entry.channel == w_chan);

    // Entries after the last pick come first in rotation order, so they win ties.
    assign w_high   = (i_idx > i_last_pick);
    assign w_cand   = (i_entry.status == ST_RUN) && i_entry.resident;
    assign w_better = (i_entry.prio < i_acc.best_pri) ||
                      ((i_entry.prio == i_acc.best_pri) && i_acc.found &&
                       w_high && !i_acc.best_high);

    // Entry update and event reporting per operation.
    always_comb begin
        o_entry = i_entry;
        o_ev    = '0;
        unique case (i_op.func)
            FUNC_WRITE: begin
                if (w_hit) begin
                    o_entry.status   = i_op.status_in;
                    o_entry.resident = i_op.resident_in;
                    o_entry.prio     = i_op.priority_req;
                    o_entry.channel  = w_chan;
                end
            end
            FUNC_SLEEP: begin
                if (w_hit) begin
                    o_entry.channel  = w_chan;
                    o_entry.prio     = i_op.priority_req;
                    o_entry.status   = i_op.priority_req[7] ? ST_SLEEP : ST_WAIT;
                end
            end
            FUNC_WAKEUP: begin
                if (w_chan_match) begin
                    o_entry.channel = '0;
                    o_entry.status  = ST_RUN;
                    o_ev.woke       = 1'b1;
                    o_ev.release_swapper = i_acc.swap_wait && !i_entry.resident;
                end
            end
            FUNC_PICK: begin
                if (w_cand && w_better) begin
                    o_ev.take      = 1'b1;
                    o_ev.take_high = w_high;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/sleep_wakeup_priority_scheduler_unit.sv */
// Top level of the sleep/wakeup priority scheduler: ring of entry cells and sequencer.
//
//  Channel  Direction  Handshake                       Payload
//  in       input      i_in_valid / o_in_ready         i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_ready       o_out_data (t_out_item)
//
// Every operation rotates the whole ring of TABLE_ENTRIES cells once past the
// head unit, one entry per cycle, then passes through the hold state, where the
// result is loaded into the output register; the next transaction can be taken
// once the sequencer is back in the idle state.
// Reset is synchronous and clears every entry, the last pick and the swapper flag.
// A new transaction is taken while an earlier result still waits at the output;
// a finished result waits in the hold state until the output register frees up.
module sleep_wakeup_priority_scheduler_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  swps_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output swps_pkg::t_out_item o_out_data
);
    import swps_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_HOLD  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_in_item          r_op;
    logic [IDX_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_last_pick;
    logic              r_swap_wait;
    logic              r_found;
    logic              r_best_high;
    logic signed [7:0] r_best_pri;
    logic [IDX_W-1:0]  r_best_idx;
    logic [6:0]        r_woken;
    logic              r_wake_sw;
    logic              r_out_valid;
    t_out_item         r_out;

    logic      w_accept;
    logic      w_shift;
    logic      w_load;
    t_entry    w_cell [TABLE_ENTRIES];
    t_entry    w_head_next;
    t_head_acc w_acc;
    t_head_ev  w_ev;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_shift  = (r_state == S_SWEEP);
    assign w_load   = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // Ring of cells: each takes its upper neighbor; the last takes the head's update.
    for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_ring
        if (j == TABLE_ENTRIES - 1) begin : g_tail
            swps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_head_next),
                .o_entry (w_cell[j])
            );
        end else begin : g_body
            swps_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_cell[j+1]),
                .o_entry (w_cell[j])
            );
        end
    end

    // Head unit sees entry r_cnt at cell zero during the sweep.
    assign w_acc.found     = r_found;
    assign w_acc.best_high = r_best_high;
    assign w_acc.best_pri  = r_best_pri;
    assign w_acc.swap_wait = r_swap_wait;

    swps_head u_head (
        .i_op        (r_op),
        .i_idx       (r_cnt),
        .i_last_pick (r_last_pick),
        .i_acc       (w_acc),
        .i_entry     (w_cell[0]),
        .o_entry     (w_head_next),
        .o_ev        (w_ev)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SWEEP;
            S_SWEEP: if (r_cnt == LAST_IDX) n_state = S_HOLD;
            S_HOLD:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last_pick <= '0;
            r_swap_wait <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (w_shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_shift && w_ev.release_swapper) begin
                r_swap_wait <= 1'b0;
            end
            if (w_load) begin
                if (r_found) begin
                    r_last_pick <= r_best_idx;
                end
                if (r_op.func == FUNC_SWAPW) begin
                    r_swap_wait <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation latch and per-item accumulators.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_in_data;
            r_found     <= 1'b0;
            r_best_high <= 1'b0;
            r_best_pri  <= PRI_NONE;
            r_best_idx  <= '0;
            r_woken     <= '0;
            r_wake_sw   <= 1'b0;
        end else if (w_shift) begin
            if (w_ev.take) begin
                r_found     <= 1'b1;
                r_best_high <= w_ev.take_high;
                r_best_pri  <= w_cell[0].prio;
                r_best_idx  <= r_cnt;
            end
            if (w_ev.woke && (r_woken != WOKEN_MAX)) begin
                r_woken <= r_woken + 1'b1;
            end
            if (w_ev.release_swapper) begin
                r_wake_sw <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.found           <= r_found;
            r_out.chosen_slot     <= r_found ? SLOT_W'(r_best_idx) : SLOT_W'(r_last_pick);
            r_out.chosen_priority <= r_found ? r_best_pri : PRI_NONE;
            r_out.woken_count     <= r_woken;
            r_out.wake_swapper    <= r_wake_sw;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
